@@ sv/bffa_pkg.sv @@
package bffa_pkg;

  localparam int MAP_WORDS_DEF = 16;
  localparam int WORD_BITS_DEF = 64;

  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int STATUS_W = 2;

  localparam logic [CNT_W-1:0] ENTRIES_RESET = 11'd1024;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_t;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] entry_to_release;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] entry_index;
    logic [CNT_W-1:0] free_count;
  } out_t;

endpackage

@@ sv/bitmap_first_free_allocator.sv @@
// Channel  | Ports                                  | Flow
// ---------+----------------------------------------+-------------------------------
// input    | start, busy, in_word (cmd, index)      | taken when start && !busy
// result   | out_valid, out_word (status,idx,free)  | one-cycle strobe, no backpressure
// config   | cfg_valid, cfg_ready, cfg_data         | entry count, ready always high
//
// Allocate: each map word passes through a read state and a check state; the registered
// RAM read sets the pace. With an entry count of zero the read state answers full at once.
// Release: S_R_WALK steps word by word to reach the entry, then a read and a write-back;
// out-of-range releases answer next cycle with busy staying low.
// After reset a clearing pass writes every map word to all-free with busy high.
// Results are registered after the final step; the receiver cannot stall.
module bitmap_first_free_allocator #(
  parameter int MAP_WORDS = bffa_pkg::MAP_WORDS_DEF,
  parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  bffa_pkg::in_t                in_word,
  output logic                         out_valid,
  output bffa_pkg::out_t               out_word,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bffa_pkg::CNT_W-1:0]   cfg_data
);

  localparam int CAP    = MAP_WORDS * WORD_BITS;
  localparam int ADDR_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WCNT_W = $clog2(MAP_WORDS + 1) > ADDR_W ? $clog2(MAP_WORDS + 1) : ADDR_W;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int CW     = ($clog2(CAP + 1) > bffa_pkg::CNT_W) ? $clog2(CAP + 1)
                                                               : bffa_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_A_RD   = 6'b000100,
    S_A_CHK  = 6'b001000,
    S_R_WALK = 6'b010000,
    S_R_CHK  = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [WCNT_W-1:0]              w_r, w_nxt;
  logic [CW-1:0]                  base_r, base_nxt;
  logic [bffa_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [bffa_pkg::CNT_W-1:0]     alloc_r, alloc_nxt;
  logic [bffa_pkg::CNT_W-1:0]     entries_r;
  logic                           out_valid_r, out_valid_nxt;
  bffa_pkg::out_t                 out_word_r, out_word_nxt;

  logic                           rd_en, wr_en;
  logic [WORD_BITS-1:0]           rdata, wr_data;
  logic [ADDR_W-1:0]              addr;

  logic [CW-1:0]                  lim_c, base_plus_wb, rem_c, free_c, alloc_ext;
  logic [CW-1:0]                  in_idx_ext, idx_ext, off_c, grant_c;
  logic [WORD_BITS-1:0]           amask, rel_bit, pos_bit;
  logic                           found;
  logic [BIT_W-1:0]               pos;
  bffa_pkg::status_t              status_c;
  logic [bffa_pkg::IDX_W-1:0]     index_c;

  assign addr = w_r[ADDR_W-1:0];

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (ADDR_W)
  ) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rdata),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (wr_data)
  );

  bffa_find #(
    .WORD_BITS (WORD_BITS),
    .BIT_W     (BIT_W)
  ) u_find (
    .word  (rdata),
    .mask  (amask),
    .found (found),
    .pos   (pos)
  );

  // effective entry count saturates at map capacity
  assign lim_c = (CW'(entries_r) < CW'(CAP)) ? CW'(entries_r) : CW'(CAP);
  assign base_plus_wb = base_r + CW'(WORD_BITS);
  assign rem_c        = lim_c - base_r;
  assign in_idx_ext   = CW'(in_word.entry_to_release);
  assign idx_ext      = CW'(idx_r);
  assign off_c        = idx_ext - base_r;
  assign grant_c      = base_r + CW'(pos);
  assign rel_bit      = {{(WORD_BITS-1){1'b0}}, 1'b1} << off_c[BIT_W-1:0];
  assign pos_bit      = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      amask[b] = (CW'(b) < rem_c);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    alloc_nxt     = alloc_r;
    out_valid_nxt = 1'b0;
    status_c      = bffa_pkg::ST_OK;
    index_c       = '0;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_data       = rdata;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '1;
        if (addr == ADDR_W'(MAP_WORDS - 1)) begin
          w_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          w_nxt = w_r + WCNT_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          w_nxt    = '0;
          base_nxt = '0;
          idx_nxt  = in_word.entry_to_release;
          if (in_word.cmd == bffa_pkg::CMD_RELEASE) begin
            if (in_idx_ext >= lim_c) begin
              out_valid_nxt = 1'b1;
              status_c      = bffa_pkg::ST_BAD_RELEASE;
            end else begin
              state_nxt = S_R_WALK;
            end
          end else begin
            state_nxt = S_A_RD;
          end
        end
      end
      S_A_RD: begin
        if (base_r >= lim_c) begin
          out_valid_nxt = 1'b1;
          status_c      = bffa_pkg::ST_FULL;
          state_nxt     = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (found) begin
          wr_en         = 1'b1;
          wr_data       = rdata & ~pos_bit;
          alloc_nxt     = alloc_r + bffa_pkg::CNT_W'(1);
          out_valid_nxt = 1'b1;
          index_c       = grant_c[bffa_pkg::IDX_W-1:0];
          state_nxt     = S_IDLE;
        end else begin
          w_nxt     = w_r + WCNT_W'(1);
          base_nxt  = base_plus_wb;
          state_nxt = S_A_RD;
        end
      end
      S_R_WALK: begin
        if (idx_ext < base_plus_wb) begin
          rd_en     = 1'b1;
          state_nxt = S_R_CHK;
        end else begin
          w_nxt    = w_r + WCNT_W'(1);
          base_nxt = base_plus_wb;
        end
      end
      S_R_CHK: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (|(rdata & rel_bit)) begin
          status_c = bffa_pkg::ST_BAD_RELEASE;
        end else begin
          wr_en   = 1'b1;
          wr_data = rdata | rel_bit;
          index_c = idx_r;
          if (alloc_r != '0) begin
            alloc_nxt = alloc_r - bffa_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // free count after this step, floored at zero
  assign alloc_ext = CW'(alloc_nxt);
  assign free_c    = (lim_c > alloc_ext) ? (lim_c - alloc_ext) : '0;

  always_comb begin
    out_word_nxt.status      = status_c;
    out_word_nxt.entry_index = index_c;
    out_word_nxt.free_count  = free_c[bffa_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      w_r         <= '0;
      base_r      <= '0;
      alloc_r     <= '0;
      entries_r   <= bffa_pkg::ENTRIES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      base_r      <= base_nxt;
      alloc_r     <= alloc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        entries_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ sv/bffa_ram.sv @@
module bffa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/bffa_find.sv @@
// Lowest set bit of one map word after masking off entries past the limit.
module bffa_find #(
  parameter int WORD_BITS = 64,
  parameter int BIT_W     = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [WORD_BITS-1:0] mask,
  output logic                 found,
  output logic [BIT_W-1:0]     pos
);

  logic [WORD_BITS-1:0] cand;

  assign cand  = word & mask;
  assign found = |cand;

  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        pos = BIT_W'(b);
      end
    end
  end

endmodule

@@ sv/bffa_chk.sv @@
module bffa_chk #(
  parameter int MAP_WORDS = bffa_pkg::MAP_WORDS_DEF,
  parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input bffa_pkg::in_t              in_word,
  input logic                       out_valid,
  input bffa_pkg::out_t             out_word,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [bffa_pkg::CNT_W-1:0] cfg_data
);

  localparam int CAP = MAP_WORDS * WORD_BITS;

  // map clearing holds off commands after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("block idle right after reset");

  // every word out traces back to an accepted command or work in progress
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result with no command behind it");

  a_error_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != bffa_pkg::ST_OK) |-> (out_word.entry_index == '0))
    else $error("error result carries nonzero index");

  a_free_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_word.free_count) <= 32'(CAP)))
    else $error("free count above map capacity");

  // an accepted allocation always keeps the block busy before it answers
  a_alloc_reads_map: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.cmd == bffa_pkg::CMD_ALLOC) |=> (busy && !out_valid))
    else $error("allocate answered without scanning");

endmodule

bind bitmap_first_free_allocator bffa_chk #(
  .MAP_WORDS (MAP_WORDS),
  .WORD_BITS (WORD_BITS)
) u_bffa_chk (.*);

@@ sim/bitmap_first_free_allocator_tb.sv @@
module bitmap_first_free_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP         = bffa_pkg::MAP_WORDS_DEF * bffa_pkg::WORD_BITS_DEF;
  localparam int WB          = bffa_pkg::WORD_BITS_DEF;
  localparam int IN_W        = $bits(bffa_pkg::in_t);
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 2 * bffa_pkg::MAP_WORDS_DEF + 8;
  localparam int N_DIR       = 22;
  localparam int N_PHASE     = 9;

  localparam logic              ALC  = bffa_pkg::CMD_ALLOC;
  localparam logic              REL  = bffa_pkg::CMD_RELEASE;
  localparam bffa_pkg::status_t OK   = bffa_pkg::ST_OK;
  localparam bffa_pkg::status_t FULL = bffa_pkg::ST_FULL;
  localparam bffa_pkg::status_t BAD  = bffa_pkg::ST_BAD_RELEASE;

  typedef struct packed {
    logic                          is_cfg;
    logic [bffa_pkg::CNT_W-1:0]    cfg_val;
    logic                          cmd;
    logic [bffa_pkg::IDX_W-1:0]    idx;
    logic                          typed;
    logic [bffa_pkg::STATUS_W-1:0] st;
    logic [bffa_pkg::IDX_W-1:0]    eidx;
    logic [bffa_pkg::CNT_W-1:0]    free;
  } dir_row_t;

  // is_cfg, cfg_val, cmd, idx, typed, status, entry_index, free_count
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{1'b0, 11'd0,    ALC, 10'd0,    1'b1, OK,   10'd0, 11'd1023},
    '{1'b0, 11'd0,    ALC, 10'd1023, 1'b1, OK,   10'd1, 11'd1022},
    '{1'b0, 11'd0,    REL, 10'd0,    1'b1, OK,   10'd0, 11'd1023},
    '{1'b0, 11'd0,    REL, 10'd0,    1'b1, BAD,  10'd0, 11'd1023},
    '{1'b0, 11'd0,    REL, 10'd1023, 1'b1, BAD,  10'd0, 11'd1023},
    '{1'b0, 11'd0,    ALC, 10'd512,  1'b0, OK,   10'd0, 11'd0},
    '{1'b0, 11'd0,    REL, 10'd512,  1'b0, OK,   10'd0, 11'd0},
    '{1'b1, 11'd0,    ALC, 10'd0,    1'b0, OK,   10'd0, 11'd0},
    '{1'b0, 11'd0,    ALC, 10'd0,    1'b1, FULL, 10'd0, 11'd0},
    '{1'b0, 11'd0,    REL, 10'd1,    1'b1, BAD,  10'd0, 11'd0},
    '{1'b1, 11'd1,    ALC, 10'd0,    1'b0, OK,   10'd0, 11'd0},
    '{1'b0, 11'd0,    ALC, 10'd0,    1'b0, OK,   10'd0, 11'd0},
    '{1'b0, 11'd0,    REL, 10'd1,    1'b0, OK,   10'd0, 11'd0},
    '{1'b0, 11'd0,    REL, 10'd0,    1'b0, OK,   10'd0, 11'd0},
    '{1'b0, 11'd0,    ALC, 10'd682,  1'b0, OK,   10'd0, 11'd0},
    '{1'b1, 11'd2047, ALC, 10'd0,    1'b0, OK,   10'd0, 11'd0},
    '{1'b0, 11'd0,    REL, 10'd1023, 1'b1, BAD,  10'd0, 11'd1022},
    '{1'b0, 11'd0,    ALC, 10'd341,  1'b0, OK,   10'd0, 11'd0},
    '{1'b0, 11'd0,    REL, 10'd1,    1'b0, OK,   10'd0, 11'd0},
    '{1'b1, 11'd1024, ALC, 10'd0,    1'b0, OK,   10'd0, 11'd0},
    '{1'b0, 11'd0,    REL, 10'd2,    1'b0, OK,   10'd0, 11'd0},
    '{1'b0, 11'd0,    ALC, 10'd0,    1'b0, OK,   10'd0, 11'd0}
  };

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  bffa_pkg::in_t              in_word;
  logic                       out_valid;
  bffa_pkg::out_t             out_word;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [bffa_pkg::CNT_W-1:0] cfg_data;

  // predictor state
  logic [bffa_pkg::WORD_BITS_DEF-1:0] free_words [bffa_pkg::MAP_WORDS_DEF];
  logic [bffa_pkg::CNT_W-1:0]         taken_count;
  logic [bffa_pkg::CNT_W-1:0]         entry_count;

  bffa_pkg::out_t due_results [$];
  bit             failed = 1'b0;
  bit             quiet;
  int unsigned    cycles = 0;

  bitmap_first_free_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic bffa_pkg::out_t predict_grant(bffa_pkg::in_t w);
    int                         lim;
    int                         i;
    bit                         found;
    logic [bffa_pkg::IDX_W-1:0] e;
    bffa_pkg::out_t             r;
    lim = (int'(entry_count) > CAP) ? CAP : int'(entry_count);
    r.status      = bffa_pkg::ST_OK;
    r.entry_index = '0;
    found         = 1'b0;
    if (w.cmd == bffa_pkg::CMD_ALLOC) begin
      for (i = 0; i < lim; i++) begin
        if (!found && free_words[i / WB][i % WB]) begin
          found = 1'b1;
          free_words[i / WB][i % WB] = 1'b0;
          taken_count   = taken_count + 1'b1;
          r.entry_index = i[bffa_pkg::IDX_W-1:0];
        end
      end
      if (!found) r.status = bffa_pkg::ST_FULL;
    end else begin
      e = w.entry_to_release;
      if (int'(e) >= lim || free_words[e / WB][e % WB]) begin
        r.status = bffa_pkg::ST_BAD_RELEASE;
      end else begin
        free_words[e / WB][e % WB] = 1'b1;
        if (taken_count != 0) taken_count = taken_count - 1'b1;
        r.entry_index = e;
      end
    end
    r.free_count = (lim > int'(taken_count)) ? bffa_pkg::CNT_W'(lim - int'(taken_count))
                                             : '0;
    return r;
  endfunction

  // some entry whose bit is clear, searched from a random spot
  function automatic logic [bffa_pkg::IDX_W-1:0] pick_taken_entry();
    int                         s;
    int                         k;
    int                         j;
    bit                         found;
    logic [bffa_pkg::IDX_W-1:0] e;
    s     = $urandom_range(CAP - 1);
    e     = s[bffa_pkg::IDX_W-1:0];
    found = 1'b0;
    for (k = 0; k < CAP; k++) begin
      j = (s + k) % CAP;
      if (!found && !free_words[j / WB][j % WB]) begin
        found = 1'b1;
        e     = j[bffa_pkg::IDX_W-1:0];
      end
    end
    return e;
  endfunction

  // called at a falling edge, returns at a falling edge with start still high
  task automatic push_item(bffa_pkg::in_t w, bit typed, bffa_pkg::out_t typed_exp);
    bffa_pkg::out_t pred;
    if (!quiet) begin
      while ($urandom_range(99) < 32) begin
        start   <= 1'b0;
        in_word <= bffa_pkg::in_t'(IN_W'($urandom));
        @(negedge clk);
      end
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    pred = predict_grant(w);
    due_results.push_back(typed ? typed_exp : pred);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (due_results.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_entries(logic [bffa_pkg::CNT_W-1:0] v);
    drain_results();
    if (!quiet) begin
      while ($urandom_range(99) < 32) @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    entry_count = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        $error("result with nothing pending: status %0d entry_index %0d free_count %0d",
               out_word.status, out_word.entry_index, out_word.free_count);
        failed = 1'b1;
      end else begin
        if (out_word.status !== due_results[0].status) begin
          $error("status: expected %0d, got %0d", due_results[0].status, out_word.status);
          failed = 1'b1;
        end
        if (out_word.entry_index !== due_results[0].entry_index) begin
          $error("entry_index: expected %0d, got %0d",
                 due_results[0].entry_index, out_word.entry_index);
          failed = 1'b1;
        end
        if (out_word.free_count !== due_results[0].free_count) begin
          $error("free_count: expected %0d, got %0d",
                 due_results[0].free_count, out_word.free_count);
          failed = 1'b1;
        end
        void'(due_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bitmap_first_free_allocator_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned    ph_cfg [N_PHASE];
    int unsigned    ph_len [N_PHASE];
    int             p;
    int             n;
    int             alloc_pct;
    int             w;
    bffa_pkg::in_t  item;
    bffa_pkg::out_t typed_exp;

    ph_cfg = '{64, 1, 130, 0, 2047, 1024, 65, 1000, 0};
    ph_len = '{250, 60, 250, 40, 150, 150, 200, 150, 150};
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    quiet     = 1'b0;
    for (w = 0; w < bffa_pkg::MAP_WORDS_DEF; w++) free_words[w] = '1;
    taken_count = '0;
    entry_count = bffa_pkg::ENTRIES_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (n = 0; n < N_DIR; n++) begin
      if (DIR_TAB[n].is_cfg) begin
        write_entries(DIR_TAB[n].cfg_val);
      end else begin
        item.cmd              = DIR_TAB[n].cmd;
        item.entry_to_release = DIR_TAB[n].idx;
        typed_exp.status      = bffa_pkg::status_t'(DIR_TAB[n].st);
        typed_exp.entry_index = DIR_TAB[n].eidx;
        typed_exp.free_count  = DIR_TAB[n].free;
        push_item(item, DIR_TAB[n].typed, typed_exp);
      end
    end

    typed_exp = '0;
    for (p = 0; p < N_PHASE; p++) begin
      quiet = (p == 2);
      if (p == N_PHASE - 1) write_entries(bffa_pkg::CNT_W'($urandom_range(2, 200)));
      else write_entries(bffa_pkg::CNT_W'(ph_cfg[p]));
      for (n = 0; n < int'(ph_len[p]); n++) begin
        // fill first, then drain back, so small maps hit full and empty
        alloc_pct = (n < int'(ph_len[p]) / 2) ? 75 : 35;
        item.entry_to_release = bffa_pkg::IDX_W'($urandom_range(CAP - 1));
        if ($urandom_range(99) < alloc_pct) begin
          item.cmd = bffa_pkg::CMD_ALLOC;
        end else begin
          item.cmd = bffa_pkg::CMD_RELEASE;
          if ($urandom_range(99) < 75) item.entry_to_release = pick_taken_entry();
        end
        push_item(item, 1'b0, typed_exp);
        if ($urandom_range(199) == 0) drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (!failed && due_results.size() == 0) begin
      $display("bitmap_first_free_allocator_tb passed");
    end else begin
      $display("bitmap_first_free_allocator_tb failed");
    end
    $finish;
  end

endmodule
